FILE: rtl/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg: shared types and constants for the sorted list block
// Word formats, operation and status codes, cell broadcast bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   // status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic               operation;
      logic signed [31:0] value;
   } sli_req_type;

   typedef struct packed {
      logic        [1:0]  status;
      logic        [4:0]  entry_count;
      logic signed [31:0] smallest_value;
      logic               list_empty;
   } sli_rsp_type;

   // command broadcast to every cell
   typedef struct packed {
      logic               ins_en;
      logic               del_en;
      logic signed [31:0] key;
   } sli_bcast_type;

   typedef enum logic {
      SLI_IDLE,
      SLI_EXEC
   } sli_state_type;

endpackage

`default_nettype wire

FILE: rtl/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete: ascending store of signed words in a cell row
// A request is latched, then the row compares and shifts as the response is
// registered, waiting while an unread response is held; one request at a time.
// Reset clears the count and rsp_valid; cell contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_delete (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire  sli_pkg::sli_req_type req_data,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output sli_pkg::sli_rsp_type       rsp_data
);
   import sli_pkg::*;

   sli_bcast_type              bcast;
   logic [CNT_W-1:0]           count;
   logic [CAPACITY-1:0]        lt_vec;
   logic [CAPACITY-1:0]        eq_vec;
   logic [CAPACITY-1:0]        valid_vec;
   logic signed [31:0]         entry_vec [CAPACITY];
   logic signed [31:0]         next_vec  [CAPACITY];
   logic                       found;

   // first matching entry exists somewhere in the row
   assign found = |eq_vec;

   sli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .found     (found),
      .head_next (next_vec[0]),
      .bcast     (bcast),
      .count     (count)
   );

   // build the cell row; cell 0 sees a smaller left neighbor
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic               left_lt;
      logic signed [31:0] left_entry;
      logic signed [31:0] right_entry;

      assign valid_vec[i] = (count > CNT_W'(i));

      if (i == 0) begin : g_first
         assign left_lt    = 1'b1;
         assign left_entry = 32'sd0;
      end else begin : g_mid
         assign left_lt    = lt_vec[i-1];
         assign left_entry = entry_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry_vec[i];
      end else begin : g_inner
         assign right_entry = entry_vec[i+1];
      end

      sli_cell u_cell (
         .clock       (clock),
         .bcast       (bcast),
         .cell_valid  (valid_vec[i]),
         .left_lt     (left_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .lt          (lt_vec[i]),
         .eq          (eq_vec[i]),
         .entry       (entry_vec[i]),
         .entry_next  (next_vec[i])
      );
   end

endmodule

`default_nettype wire

FILE: rtl/sli_cell.sv
// ----------------------------------------------------------------------------
// sli_cell: one slot of the sorted list
// Compares its entry with the broadcast key and shifts right on insert or
// left on delete, taking the neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_cell (
   input  wire                         clock,
   input  wire  sli_pkg::sli_bcast_type bcast,
   input  wire                         cell_valid,
   input  wire                         left_lt,
   input  wire  signed [31:0]          left_entry,
   input  wire  signed [31:0]          right_entry,
   output logic                        lt,
   output logic                        eq,
   output logic signed [31:0]          entry,
   output logic signed [31:0]          entry_next
);
   import sli_pkg::*;

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;
   logic               ge;

   // compare own entry with the key
   always_comb begin
      lt = cell_valid && (entry_ff <  bcast.key);
      ge = cell_valid && (entry_ff >= bcast.key);
      eq = cell_valid && (entry_ff == bcast.key);
   end

   // pick next entry: hold, take key, take left word, or take right word
   always_comb begin
      entry_in = entry_ff;
      if (bcast.ins_en && !lt) begin
         entry_in = left_lt ? bcast.key : left_entry;
      end else if (bcast.del_en && ge) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

`default_nettype wire

FILE: rtl/sli_ctrl.sv
// ----------------------------------------------------------------------------
// sli_ctrl: sequencer, entry count and response register
// Latches a request, drives the cell row for one cycle, forms the response.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  sli_pkg::sli_req_type   req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output sli_pkg::sli_rsp_type         rsp_data,
   input  wire                          found,
   input  wire  signed [31:0]           head_next,
   output sli_pkg::sli_bcast_type       bcast,
   output logic [sli_pkg::CNT_W-1:0]    count
);
   import sli_pkg::*;

   sli_state_type      state_ff, state_in;
   logic               op_ff;
   logic signed [31:0] value_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sli_rsp_type        rsp_ff, rsp_in;
   logic               go;
   logic               full;
   logic [1:0]         status;
   logic [CNT_W+4:0]   count_ext;

   assign full = (count_ff == CNT_W'(CAPACITY));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SLI_IDLE: begin
            if (req_valid) state_in = SLI_EXEC;
         end
         SLI_EXEC: begin
            if (go) state_in = SLI_IDLE;
         end
         default: state_in = SLI_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      go        = 1'b0;
      case (state_ff)
         SLI_IDLE: req_ready = 1'b1;
         SLI_EXEC: go = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            go        = 1'b0;
         end
      endcase
   end

   // drive the cell row and update the count
   always_comb begin
      bcast.key    = value_ff;
      bcast.ins_en = go && (op_ff == OP_INSERT) && !full;
      bcast.del_en = go && (op_ff == OP_DELETE) && found;
      count_in     = count_ff;
      if (bcast.ins_en) count_in = count_ff + CNT_W'(1);
      if (bcast.del_en) count_in = count_ff - CNT_W'(1);
      if (op_ff == OP_INSERT) begin
         status = full ? ST_FULL : ST_DONE;
      end else begin
         status = found ? ST_DONE : ST_NOT_FOUND;
      end
   end

   // form the response word
   always_comb begin
      count_ext             = {5'b0, count_in};
      rsp_in                = rsp_ff;
      rsp_valid_in          = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (go) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = status;
         rsp_in.entry_count    = count_ext[4:0];
         rsp_in.list_empty     = (count_in == '0);
         rsp_in.smallest_value = (count_in == '0) ? 32'sd0 : head_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SLI_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the operand and response payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff    <= req_data.operation;
         value_ff <= req_data.value;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign count     = count_ff;

endmodule

`default_nettype wire
